FILE: rtl/bitmap_frame_allocator_assert.svh
// assertion macros of the bitmap frame allocator top level
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfa assertion failed");
// next-cycle implication
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfa assertion failed");
`else
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/bfa_pkg.sv
// types and constants of the bitmap frame allocator
package bfa_pkg;

   localparam int MAX_FRAMES = 65536;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
   localparam int WORD_AW    = $clog2(NUM_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WCNT_W     = WORD_AW + 1;
   localparam int FRAME_W    = 16;
   localparam int CFG_W      = 17;
   localparam int STATUS_W   = 2;

   // request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MAPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTHING = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } bfa_state_type;

   // result of the lowest-zero search over one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } bfa_zero_type;

endpackage

FILE: rtl/bitmap_frame_allocator.sv
// first-fit bitmap page frame allocator, top level
//
//  port group  dir  flow control         contents
//  req_*       in   req_valid/req_stall  request type, page frame, kernel, writeable
//  rsp_*       out  rsp_valid/rsp_stall  new frame, present/rw/user bits, status
//  csr_*       in   csr_write_en         active frame count
//
// After reset the bitmap memory is cleared one word a cycle with req_stall
// high; csr writes are taken during that time.
// Allocate: one memory read and one lowest-zero search per bitmap word scanned,
// up to 2048 words. Free: a memory read, then a write of the cleared bit.
// Mapped, nothing-to-free and empty-range requests go straight to the response.
// A finished word waits in the response register; the next request is taken
// meanwhile and holds in its last state while rsp_stall keeps the slot full.
`include "bitmap_frame_allocator_assert.svh"
module bitmap_frame_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [bfa_pkg::FRAME_W-1:0]   req_page_frame,
   input  logic                          req_is_kernel,
   input  logic                          req_is_writeable,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bfa_pkg::FRAME_W-1:0]   rsp_new_frame,
   output logic                          rsp_present_bit,
   output logic                          rsp_rw_bit,
   output logic                          rsp_user_bit,
   output logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_write_en,
   input  logic [bfa_pkg::CFG_W-1:0]     csr_write_data
);
   import bfa_pkg::*;

   bfa_state_type            state_ff, state_in;
   logic [WORD_AW-1:0]       clr_ff, clr_in;
   logic [WCNT_W-1:0]        word_count_ff, word_count_in;
   logic [WORD_AW-1:0]       word_ff, word_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic                     kern_ff, kern_in;
   logic                     wr_ff, wr_in;
   logic [FRAME_W-1:0]       res_frame_ff, res_frame_in;
   logic                     res_present_ff, res_present_in;
   logic                     res_rw_ff, res_rw_in;
   logic                     res_user_ff, res_user_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]       rsp_frame_ff;
   logic                     rsp_present_ff, rsp_rw_ff, rsp_user_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   logic                     req_take;
   logic                     load_rsp;
   logic                     ram_we, ram_re;
   logic [WORD_AW-1:0]       ram_addr;
   logic [WORD_BITS-1:0]     ram_wdata, ram_rdata;
   logic [WORD_BITS-1:0]     bit_mask;
   logic [WCNT_W-1:0]        next_word;
   logic [CFG_W-1:0]         cfg_words;
   bfa_zero_type             zero;

   // bitmap memory and the lowest-zero word search
   bfa_ram #(
      .DEPTH(NUM_WORDS),
      .WIDTH(WORD_BITS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   bfa_first_zero u_zero (
      .word (ram_rdata),
      .zero (zero)
   );

   assign req_take  = req_valid && !req_stall;
   assign next_word = {1'b0, word_ff} + WCNT_W'(1);
   assign bit_mask  = WORD_BITS'(1) << bit_ff;
   assign cfg_words = csr_write_data >> BIT_W;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_ALLOC && req_page_frame == '0 && word_count_ff != '0) begin
                  state_in = ST_SCAN_RD;
               end else if (req_type == REQ_FREE && req_page_frame != '0) begin
                  state_in = ST_FREE_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (zero.found || next_word >= word_count_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_FREE_RD:  state_in = ST_FREE_WR;
         ST_FREE_WR:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:     state_in = ST_CLEAR;
      endcase
   end

   // sequencer outputs: memory controls, stall, response load
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = word_ff;
      ram_wdata = '0;
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
         end
         ST_IDLE:     req_stall = 1'b0;
         ST_SCAN_RD:  ram_re = 1'b1;
         ST_SCAN_CHK: begin
            ram_we    = zero.found;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << zero.idx);
         end
         ST_FREE_RD:  ram_re = 1'b1;
         ST_FREE_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
         end
         ST_DONE:     load_rsp = !rsp_valid_ff || !rsp_stall;
         default:     req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in         = clr_ff;
      word_count_in  = word_count_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      kern_in        = kern_ff;
      wr_in          = wr_ff;
      res_frame_in   = res_frame_ff;
      res_present_in = res_present_ff;
      res_rw_in      = res_rw_ff;
      res_user_in    = res_user_ff;
      res_status_in  = res_status_ff;

      // active frame count, whole words, saturated
      if (csr_write_en) begin
         if (cfg_words > CFG_W'(NUM_WORDS)) begin
            word_count_in = WCNT_W'(NUM_WORDS);
         end else begin
            word_count_in = WCNT_W'(cfg_words);
         end
      end

      if (state_ff == ST_CLEAR) clr_in = clr_ff + WORD_AW'(1);

      // request intake
      if (req_take) begin
         word_in        = '0;
         bit_in         = req_page_frame[BIT_W-1:0];
         kern_in        = req_is_kernel;
         wr_in          = req_is_writeable;
         res_frame_in   = '0;
         res_present_in = 1'b0;
         res_rw_in      = 1'b0;
         res_user_in    = 1'b0;
         res_status_in  = STAT_DONE;
         if (req_type == REQ_ALLOC) begin
            if (req_page_frame != '0) begin
               res_frame_in  = req_page_frame;
               res_status_in = STAT_MAPPED;
            end else if (word_count_ff == '0) begin
               res_status_in = STAT_NO_FREE;
            end
         end else begin
            word_in = req_page_frame[FRAME_W-1:BIT_W];
            if (req_page_frame == '0) res_status_in = STAT_NOTHING;
         end
      end

      // scan step result
      if (state_ff == ST_SCAN_CHK) begin
         if (zero.found) begin
            res_frame_in   = {word_ff, zero.idx};
            res_present_in = 1'b1;
            res_rw_in      = wr_ff;
            res_user_in    = !kern_ff;
            res_status_in  = STAT_DONE;
         end else if (next_word >= word_count_ff) begin
            res_status_in = STAT_NO_FREE;
         end else begin
            word_in = next_word[WORD_AW-1:0];
         end
      end
   end

   // response slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         word_count_ff <= WCNT_W'(NUM_WORDS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         word_count_ff <= word_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      kern_ff        <= kern_in;
      wr_ff          <= wr_in;
      res_frame_ff   <= res_frame_in;
      res_present_ff <= res_present_in;
      res_rw_ff      <= res_rw_in;
      res_user_ff    <= res_user_in;
      res_status_ff  <= res_status_in;
      if (load_rsp) begin
         rsp_frame_ff   <= res_frame_ff;
         rsp_present_ff <= res_present_ff;
         rsp_rw_ff      <= res_rw_ff;
         rsp_user_ff    <= res_user_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_frame   = rsp_frame_ff;
   assign rsp_present_bit = rsp_present_ff;
   assign rsp_rw_bit      = rsp_rw_ff;
   assign rsp_user_bit    = rsp_user_ff;
   assign rsp_status      = rsp_status_ff;

   // checks
   `BFA_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == ST_SCAN_CHK, {1'b0, word_ff} < word_count_ff)
   `BFA_ASSERT_NXT(a_done_holds, clock, reset, state_ff == ST_DONE && rsp_valid_ff && rsp_stall, state_ff == ST_DONE)
   `BFA_ASSERT_IMP(a_clear_stalls, clock, reset, state_ff == ST_CLEAR, req_stall && !ram_re)

endmodule

FILE: rtl/bfa_ram.sv
// single-port bitmap word memory with registered read data
module bfa_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/bfa_first_zero.sv
// lowest clear bit search over one bitmap word
module bfa_first_zero (
   input  logic [bfa_pkg::WORD_BITS-1:0] word,
   output bfa_pkg::bfa_zero_type         zero
);
   import bfa_pkg::*;

   // priority encode, lowest index wins
   always_comb begin
      zero.found = ~&word;
      zero.idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            zero.idx = BIT_W'(i);
         end
      end
   end

endmodule
